// ===== rtl/core/lwbc_pkg.sv =====
// Shared codes, command and status types of the block cache tag engine.
package lwbc_pkg;

	localparam logic [2:0] MODE_RD    = 3'd0;
	localparam logic [2:0] MODE_WR    = 3'd1;
	localparam logic [2:0] MODE_PLACE = 3'd2;
	localparam logic [2:0] MODE_DIRTY = 3'd3;
	localparam logic [2:0] MODE_INVAL = 3'd4;
	localparam logic [2:0] MODE_CLOSE = 3'd5;
	localparam logic [2:0] MODE_STAT  = 3'd6;

	localparam int STAT_COUNT = 7;
	localparam logic [2:0] ST_RD_HIT      = 3'd0;
	localparam logic [2:0] ST_WR_HIT      = 3'd1;
	localparam logic [2:0] ST_EVICT       = 3'd2;
	localparam logic [2:0] ST_WB          = 3'd3;
	localparam logic [2:0] ST_INVAL       = 3'd4;
	localparam logic [2:0] ST_CLOSE_WB    = 3'd5;
	localparam logic [2:0] ST_CLOSE_EVICT = 3'd6;
	localparam logic [2:0] ST_NONE        = 3'd7;

	localparam int STAMP_W = 48;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_step;
		logic evict;
		logic flush_step;
		logic final_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       any_hit;
		logic       any_empty;
		logic       walk_last;
		logic       out_busy;
	} sts_t;

endpackage

// ===== rtl/core/lwbc_ctrl.sv =====
// Controller state machine of the block cache tag engine.
module lwbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lwbc_pkg::sts_t sts,
	output lwbc_pkg::cmd_t cmd
);
	import lwbc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_EVICT = 7'b0001000,
		S_FLUSH = 7'b0010000,
		S_FINAL = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.mode == MODE_CLOSE) begin
					state_d = S_FLUSH;
				end else if (sts.mode == MODE_PLACE && !sts.any_hit && !sts.any_empty) begin
					state_d = S_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_OUT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.walk_last)
					state_d = S_EVICT;
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = S_OUT;
			end
			S_FLUSH: begin
				if (!sts.out_busy) begin
					cmd.flush_step = 1'b1;
					if (sts.walk_last)
						state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				if (!sts.out_busy) begin
					cmd.final_out = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/lwbc_dp.sv =====
// Datapath of the block cache tag engine: slot store, tag match, LRU walk, counters.
module lwbc_dp #(
	parameter int CACHE_SLOTS  = 16,
	parameter int SERVER_COUNT = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lwbc_pkg::cmd_t cmd,
	output lwbc_pkg::sts_t sts,
	input  logic [2:0]    mode,
	input  logic [15:0]   file_id,
	input  logic [31:0]   block_number,
	input  logic          mark_dirty,
	input  logic [2:0]    server_id,
	input  logic [2:0]    stat_select,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          hit,
	output logic [3:0]    slot,
	output logic          writeback_valid,
	output logic [15:0]   writeback_file,
	output logic [31:0]   writeback_block,
	output logic [2:0]    writeback_server,
	output logic [31:0]   stat_value,
	output logic          last
);
	import lwbc_pkg::*;

	localparam int IW = $clog2(CACHE_SLOTS);

	logic [2:0]  it_mode_q;
	logic [15:0] it_file_q;
	logic [31:0] it_block_q;
	logic        it_md_q;
	logic [2:0]  it_srv_q;
	logic [2:0]  it_sel_q;

	logic               v_q  [CACHE_SLOTS];
	logic               d_q  [CACHE_SLOTS];
	logic [15:0]        sf_q [CACHE_SLOTS];
	logic [31:0]        sb_q [CACHE_SLOTS];
	logic [2:0]         ss_q [CACHE_SLOTS];
	logic [STAMP_W-1:0] st_q [CACHE_SLOTS];
	logic [STAMP_W-1:0] ctr_q;
	logic [31:0]        stat_q [STAT_COUNT];

	logic [IW-1:0]      walk_q, best_q;
	logic [STAMP_W-1:0] best_st_q;

	logic out_valid_q, o_hit_q, o_wbv_q, o_last_q;
	logic [3:0]  o_slot_q;
	logic [15:0] o_wbf_q;
	logic [31:0] o_wbb_q, o_stat_q;
	logic [2:0]  o_wbs_q;

	logic [CACHE_SLOTS-1:0] hv;
	logic [IW-1:0] hidx, eidx;
	logic any_hit, any_empty, fm;
	logic [2:0] srv_c;

	logic touch_en, fill_en, upd_en, setd_en, clr_en, oload;
	logic [IW-1:0] touch_idx, fill_idx, upd_idx, setd_idx, clr_idx, wb_idx;
	logic [STAT_COUNT-1:0] bump;
	logic n_hit, n_wbv, n_last;
	logic [IW-1:0] n_slot;
	logic [31:0] n_stat;

	assign srv_c = (32'(it_srv_q) >= SERVER_COUNT) ? 3'(SERVER_COUNT - 1) : it_srv_q;

	always_comb begin
		hv        = '0;
		hidx      = '0;
		eidx      = '0;
		any_empty = 1'b0;
		for (int i = 0; i < CACHE_SLOTS; i++)
			hv[i] = v_q[i] && sf_q[i] == it_file_q && sb_q[i] == it_block_q;
		for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
			if (hv[i])
				hidx = IW'(i);
			if (!v_q[i]) begin
				eidx      = IW'(i);
				any_empty = 1'b1;
			end
		end
	end

	assign any_hit = |hv;
	assign fm      = v_q[walk_q] && sf_q[walk_q] == it_file_q;

	assign sts.mode      = it_mode_q;
	assign sts.any_hit   = any_hit;
	assign sts.any_empty = any_empty;
	assign sts.walk_last = walk_q == IW'(CACHE_SLOTS - 1);
	assign sts.out_busy  = out_valid_q;

	always_comb begin
		touch_en  = 1'b0; touch_idx = '0;
		fill_en   = 1'b0; fill_idx  = '0;
		upd_en    = 1'b0; upd_idx   = '0;
		setd_en   = 1'b0; setd_idx  = '0;
		clr_en    = 1'b0; clr_idx   = '0;
		bump      = '0;
		oload     = 1'b0;
		n_hit     = 1'b0;
		n_slot    = '0;
		n_wbv     = 1'b0;
		wb_idx    = '0;
		n_stat    = '0;
		n_last    = 1'b1;
		if (cmd.exec) begin
			oload = 1'b1;
			case (it_mode_q)
				MODE_RD, MODE_WR: begin
					n_hit  = any_hit;
					n_slot = hidx;
					if (any_hit) begin
						touch_en  = 1'b1;
						touch_idx = hidx;
						bump[(it_mode_q == MODE_RD) ? ST_RD_HIT : ST_WR_HIT] = 1'b1;
					end
				end
				MODE_PLACE: begin
					if (any_hit) begin
						n_hit     = 1'b1;
						n_slot    = hidx;
						touch_en  = 1'b1;
						touch_idx = hidx;
						upd_en    = 1'b1;
						upd_idx   = hidx;
					end else begin
						n_slot    = eidx;
						fill_en   = 1'b1;
						fill_idx  = eidx;
						touch_en  = 1'b1;
						touch_idx = eidx;
					end
				end
				MODE_DIRTY: begin
					n_hit    = any_hit;
					n_slot   = hidx;
					setd_en  = any_hit;
					setd_idx = hidx;
				end
				MODE_INVAL: begin
					if (any_hit) begin
						n_hit  = 1'b1;
						n_slot = hidx;
						if (d_q[hidx]) begin
							n_wbv      = 1'b1;
							wb_idx     = hidx;
							bump[ST_WB] = 1'b1;
						end
						bump[ST_INVAL] = 1'b1;
						clr_en  = 1'b1;
						clr_idx = hidx;
					end
				end
				MODE_STAT: begin
					if (it_sel_q != ST_NONE)
						n_stat = stat_q[it_sel_q];
				end
				default: ;
			endcase
		end
		if (cmd.evict) begin
			oload          = 1'b1;
			n_slot         = best_q;
			bump[ST_EVICT] = 1'b1;
			if (d_q[best_q]) begin
				n_wbv       = 1'b1;
				wb_idx      = best_q;
				bump[ST_WB] = 1'b1;
			end
			fill_en   = 1'b1;
			fill_idx  = best_q;
			touch_en  = 1'b1;
			touch_idx = best_q;
		end
		if (cmd.flush_step && fm) begin
			if (d_q[walk_q]) begin
				oload             = 1'b1;
				n_wbv             = 1'b1;
				wb_idx            = walk_q;
				n_slot            = walk_q;
				n_last            = 1'b0;
				bump[ST_WB]       = 1'b1;
				bump[ST_CLOSE_WB] = 1'b1;
			end
			bump[ST_EVICT]       = 1'b1;
			bump[ST_CLOSE_EVICT] = 1'b1;
			clr_en  = 1'b1;
			clr_idx = walk_q;
		end
		if (cmd.final_out)
			oload = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_mode_q  <= mode;
			it_file_q  <= file_id;
			it_block_q <= block_number;
			it_md_q    <= mark_dirty;
			it_srv_q   <= server_id;
			it_sel_q   <= stat_select;
		end
		if (fill_en) begin
			sf_q[fill_idx] <= it_file_q;
			sb_q[fill_idx] <= it_block_q;
			ss_q[fill_idx] <= srv_c;
		end
		if (upd_en)
			ss_q[upd_idx] <= srv_c;
		if (touch_en)
			st_q[touch_idx] <= ctr_q + 1'b1;
		if (cmd.scan_step && (walk_q == '0 || st_q[walk_q] < best_st_q)) begin
			best_q    <= walk_q;
			best_st_q <= st_q[walk_q];
		end
		if (oload) begin
			o_hit_q  <= n_hit;
			o_slot_q <= 4'(n_slot);
			o_wbv_q  <= n_wbv;
			o_wbf_q  <= n_wbv ? sf_q[wb_idx] : '0;
			o_wbb_q  <= n_wbv ? sb_q[wb_idx] : '0;
			o_wbs_q  <= n_wbv ? ss_q[wb_idx] : '0;
			o_stat_q <= n_stat;
			o_last_q <= n_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_SLOTS; i++) begin
				v_q[i] <= 1'b0;
				d_q[i] <= 1'b0;
			end
			for (int i = 0; i < STAT_COUNT; i++)
				stat_q[i] <= '0;
			ctr_q       <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fill_en) begin
				v_q[fill_idx] <= 1'b1;
				d_q[fill_idx] <= it_md_q;
			end
			if (upd_en && it_md_q)
				d_q[upd_idx] <= 1'b1;
			if (setd_en)
				d_q[setd_idx] <= 1'b1;
			if (clr_en) begin
				v_q[clr_idx] <= 1'b0;
				d_q[clr_idx] <= 1'b0;
			end
			for (int i = 0; i < STAT_COUNT; i++)
				if (bump[i])
					stat_q[i] <= stat_q[i] + 1'b1;
			if (touch_en)
				ctr_q <= ctr_q + 1'b1;
			if (cmd.load)
				walk_q <= '0;
			else if (cmd.scan_step || cmd.flush_step)
				walk_q <= walk_q + 1'b1;
			if (oload)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = o_hit_q;
	assign slot             = o_slot_q;
	assign writeback_valid  = o_wbv_q;
	assign writeback_file   = o_wbf_q;
	assign writeback_block  = o_wbb_q;
	assign writeback_server = o_wbs_q;
	assign stat_value       = o_stat_q;
	assign last             = o_last_q;

endmodule

// ===== rtl/core/lru_writeback_block_cache_tags.sv =====
// Top level of the fully associative write-back block cache tag engine.
// One item is taken at a time. Lookup, place into a free or matching slot,
// mark dirty, invalidate, statistic read and unknown modes give their single
// result, registered from the lookup state, and take new items again once
// that result is taken. A place that must evict walks the stamps of all
// slots, one slot a cycle, to find the oldest, then registers its result. A
// close flush walks every slot, one a cycle, and pauses at each writeback
// result until it is taken; a final result follows the walk. Tag match is
// done on all slots at once.
module lru_writeback_block_cache_tags #(
	parameter int CACHE_SLOTS  = 16,
	parameter int SERVER_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [15:0] file_id,
	input  logic [31:0] block_number,
	input  logic        mark_dirty,
	input  logic [2:0]  server_id,
	input  logic [2:0]  stat_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [3:0]  slot,
	output logic        writeback_valid,
	output logic [15:0] writeback_file,
	output logic [31:0] writeback_block,
	output logic [2:0]  writeback_server,
	output logic [31:0] stat_value,
	output logic        last
);
	import lwbc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lwbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lwbc_dp #(
		.CACHE_SLOTS  (CACHE_SLOTS),
		.SERVER_COUNT (SERVER_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.file_id          (file_id),
		.block_number     (block_number),
		.mark_dirty       (mark_dirty),
		.server_id        (server_id),
		.stat_select      (stat_select),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.slot             (slot),
		.writeback_valid  (writeback_valid),
		.writeback_file   (writeback_file),
		.writeback_block  (writeback_block),
		.writeback_server (writeback_server),
		.stat_value       (stat_value),
		.last             (last)
	);

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("item taken while a result is pending");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |-> ##2 in_ready)
		else $error("block not idle after final result");

	a_mid_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> writeback_valid && !hit)
		else $error("non-final result without writeback");

	a_wb_nostat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && writeback_valid |-> stat_value == 32'd0)
		else $error("writeback result carries a statistic");

endmodule
